@@ rtl/core/sqlat_pkg.sv @@
// ----------------------------------------------------------------------------
// sqlat_pkg
// Shared types and constants for the SQL array literal tokenizer: parse
// phases, event codes, character constants and the decoded burst format.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlat_pkg;

  // Parse phase of the tokenizer
  typedef enum logic [2:0] {
    PH_START    = 3'd0,  // start of a token
    PH_SEP      = 3'd1,  // just after a token, one separator may be skipped
    PH_SQ       = 3'd2,  // inside a single-quoted string
    PH_SQ_QUOTE = 3'd3,  // quote seen inside a single-quoted string
    PH_DQ       = 3'd4,  // inside a double-quoted string
    PH_ESC      = 3'd5,  // after a backslash in a quoted string
    PH_UNQ      = 3'd6,  // inside an unquoted element
    PH_END      = 3'd7   // text ended
  } phase_t;

  // Event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_ROW_START = 3'd0,
    EV_ROW_END   = 3'd1,
    EV_BYTE      = 3'd2,
    EV_VALUE_END = 3'd3,
    EV_NULL      = 3'd4,
    EV_DONE      = 3'd5,
    EV_ERR_ZERO  = 3'd6,
    EV_ERR_ESC   = 3'd7
  } event_t;

  // Characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Length of the word NULL
  localparam logic [2:0] NULL_LEN = 3'd4;

  // Character i of the word NULL
  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h4E;  // N
      2'd1:    ch = 8'h55;  // U
      default: ch = 8'h4C;  // L
    endcase
    return ch;
  endfunction

  // Tokenizer state carried from item to item
  typedef struct packed {
    phase_t     phase;
    logic [2:0] npc;   // held bytes matching the start of NULL
    logic       uf;    // unquoted: bytes flushed; escape: return to DQ
  } tok_state_t;

  // One event of a burst other than a released NULL prefix byte
  typedef struct packed {
    event_t     kind;
    logic [7:0] ch;
  } tail_ev_t;

  // All results of one item: released prefix bytes, then up to two events
  typedef struct packed {
    logic [2:0]          flush_cnt;
    tail_ev_t [1:0]      tail;
    logic [1:0]          tail_cnt;
  } burst_t;

endpackage

`default_nettype wire

@@ rtl/core/sqlat_decode.sv @@
// ----------------------------------------------------------------------------
// sqlat_decode
// Next-state and result decode for one text byte: gives the number of held
// NULL prefix bytes to release, the following events and the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlat_decode (
  input  wire logic [7:0]          text_byte,
  input  wire sqlat_pkg::tok_state_t st_i,
  output sqlat_pkg::tok_state_t    st_nxt,
  output sqlat_pkg::burst_t        burst
);
  import sqlat_pkg::*;

  logic       is_sep;
  logic       is_term;
  logic       tok_go;   // byte handled as the start of a token
  logic       unq_go;   // byte handled as part of an unquoted element
  logic [2:0] cur_npc;
  logic       cur_uf;

  assign is_sep  = (text_byte == CH_COMMA) || (text_byte == CH_SEMI);
  assign is_term = is_sep || (text_byte == CH_RBRACE) || (text_byte == CH_NUL);

  always_comb begin
    st_nxt  = st_i;
    burst   = '0;
    tok_go  = 1'b0;
    unq_go  = 1'b0;
    cur_npc = st_i.npc;
    cur_uf  = st_i.uf;

    // phase-specific handling
    case (st_i.phase)
      PH_START: begin
        tok_go = 1'b1;
      end
      PH_SEP: begin
        if (is_sep) st_nxt.phase = PH_START;
        else        tok_go = 1'b1;
      end
      PH_SQ: begin
        if (text_byte == CH_NUL) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_ERR_ZERO, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_END;
        end else if (text_byte == CH_SQUOTE) begin
          st_nxt.phase = PH_SQ_QUOTE;
        end else if (text_byte == CH_BSLASH) begin
          st_nxt.uf    = 1'b0;
          st_nxt.phase = PH_ESC;
        end else begin
          burst.tail[burst.tail_cnt[0]] = '{EV_BYTE, text_byte};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
        end
      end
      PH_SQ_QUOTE: begin
        if (text_byte == CH_SQUOTE) begin
          // doubled quote
          burst.tail[burst.tail_cnt[0]] = '{EV_BYTE, text_byte};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_SQ;
        end else begin
          // string closed: value end, then treat byte as after a token
          burst.tail[burst.tail_cnt[0]] = '{EV_VALUE_END, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          if (is_sep) st_nxt.phase = PH_START;
          else        tok_go = 1'b1;
        end
      end
      PH_DQ: begin
        if (text_byte == CH_NUL) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_ERR_ZERO, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_END;
        end else if (text_byte == CH_BSLASH) begin
          st_nxt.uf    = 1'b1;
          st_nxt.phase = PH_ESC;
        end else if (text_byte == CH_DQUOTE) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_VALUE_END, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_SEP;
        end else begin
          burst.tail[burst.tail_cnt[0]] = '{EV_BYTE, text_byte};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
        end
      end
      PH_ESC: begin
        if (text_byte == CH_NUL) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_ERR_ESC, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_END;
        end else begin
          burst.tail[burst.tail_cnt[0]] = '{EV_BYTE, text_byte};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = st_i.uf ? PH_DQ : PH_SQ;
        end
        st_nxt.uf = 1'b0;
      end
      PH_UNQ: begin
        unq_go = 1'b1;
      end
      default: begin
        // ended: done on every byte
        burst.tail[burst.tail_cnt[0]] = '{EV_DONE, 8'h00};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.phase = PH_END;
      end
    endcase

    // start of a token
    if (tok_go) begin
      if (text_byte == CH_NUL) begin
        burst.tail[burst.tail_cnt[0]] = '{EV_DONE, 8'h00};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.phase = PH_END;
      end else if (text_byte == CH_LBRACE) begin
        burst.tail[burst.tail_cnt[0]] = '{EV_ROW_START, 8'h00};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.phase = PH_SEP;
      end else if (text_byte == CH_RBRACE) begin
        burst.tail[burst.tail_cnt[0]] = '{EV_ROW_END, 8'h00};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.phase = PH_SEP;
      end else if (text_byte == CH_SQUOTE) begin
        st_nxt.phase = PH_SQ;
      end else if (text_byte == CH_DQUOTE) begin
        st_nxt.phase = PH_DQ;
      end else if (is_sep) begin
        // empty unquoted element
        burst.tail[burst.tail_cnt[0]] = '{EV_VALUE_END, 8'h00};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.phase = PH_START;
      end else begin
        st_nxt.phase = PH_UNQ;
        cur_npc = 3'd0;
        cur_uf  = 1'b0;
        unq_go  = 1'b1;
      end
    end

    // unquoted element, with NULL prefix hold-back
    if (unq_go) begin
      st_nxt.npc = cur_npc;
      st_nxt.uf  = cur_uf;
      if (is_term) begin
        if (!cur_uf && (cur_npc == NULL_LEN)) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_NULL, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
        end else begin
          burst.flush_cnt = cur_npc;
          burst.tail[burst.tail_cnt[0]] = '{EV_VALUE_END, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
        end
        st_nxt.npc = 3'd0;
        st_nxt.uf  = 1'b0;
        if (text_byte == CH_NUL) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_DONE, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_END;
        end else if (text_byte == CH_RBRACE) begin
          burst.tail[burst.tail_cnt[0]] = '{EV_ROW_END, 8'h00};
          burst.tail_cnt = burst.tail_cnt + 2'd1;
          st_nxt.phase = PH_SEP;
        end else begin
          st_nxt.phase = PH_START;
        end
      end else if (!cur_uf && (cur_npc < NULL_LEN) &&
                   (text_byte == null_char(cur_npc[1:0]))) begin
        st_nxt.npc = cur_npc + 3'd1;
      end else begin
        burst.flush_cnt = cur_npc;
        burst.tail[burst.tail_cnt[0]] = '{EV_BYTE, text_byte};
        burst.tail_cnt = burst.tail_cnt + 2'd1;
        st_nxt.npc = 3'd0;
        st_nxt.uf  = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sql_array_literal_tokenizer.sv @@
// ----------------------------------------------------------------------------
// sql_array_literal_tokenizer
// Byte-stream tokenizer for SQL array literals, emitting row, value, null,
// done and error events.
// ----------------------------------------------------------------------------
// Each text byte is decoded in the cycle it is accepted and its results are
// written to a burst register that drains one result per cycle while the
// receiver is ready. A byte that gives zero or one result does not hold the
// input, so ordinary text then streams at one byte per cycle; a byte that
// gives more (up to five, when a held-back NULL prefix is released) holds the
// input until its last result is taken, bounded by the single output register.
// The next byte is taken in the same cycle as the last result of the previous
// one. Text ends on a zero byte; then every byte gives a done event until reset.
`default_nettype none

module sql_array_literal_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  // result items
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] value_char
  output logic [2:0]      out_tuser,  // [2:0] event_kind
  output logic            out_tlast   // run_last
);
  import sqlat_pkg::*;

  tok_state_t state_r;
  tok_state_t state_nxt;
  burst_t     burst_r;
  burst_t     burst_nxt;
  logic [2:0] total_r;
  logic [2:0] rd_r;
  logic       in_acc;
  logic       out_acc;
  logic [2:0] rd_inc;
  logic [2:0] tail_pos;
  tail_ev_t   tail_sel;

  // decode of the incoming byte
  sqlat_decode u_decode (
    .text_byte (in_tdata),
    .st_i      (state_r),
    .st_nxt    (state_nxt),
    .burst     (burst_nxt)
  );

  // handshakes: take a byte once the burst is empty or on its last result
  assign rd_inc     = rd_r + 3'd1;
  assign out_tvalid = (rd_r != total_r);
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = (rd_r == total_r) || ((rd_inc == total_r) && out_tready);
  assign in_acc     = in_tvalid && in_tready;

  // state and burst registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{PH_START, 3'd0, 1'b0};
      total_r <= 3'd0;
      rd_r    <= 3'd0;
    end else if (in_acc) begin
      state_r <= state_nxt;
      total_r <= burst_nxt.flush_cnt + {1'b0, burst_nxt.tail_cnt};
      rd_r    <= 3'd0;
    end else if (out_acc) begin
      rd_r    <= rd_inc;
    end
  end

  // burst payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) burst_r <= burst_nxt;
  end

  // result select: released prefix bytes first, then the tail events
  assign tail_pos = rd_r - burst_r.flush_cnt;
  assign tail_sel = burst_r.tail[tail_pos[0]];

  always_comb begin
    if (rd_r < burst_r.flush_cnt) begin
      out_tuser = EV_BYTE;
      out_tdata = null_char(rd_r[1:0]);
    end else begin
      out_tuser = tail_sel.kind;
      out_tdata = tail_sel.ch;
    end
  end

  assign out_tlast = (rd_inc == total_r);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sql_array_literal_tokenizer. A directed table of
// text bytes runs first, then randomly built array literals (braces,
// separators, plain, NULL-like, single- and double-quoted elements with
// escapes, and stray bytes), and finally one randomly chosen way of ending
// the text followed by a few bytes into the ended state. Every accepted byte
// is run through a local tokenizer model and the result items are compared
// in order on kind, character and last flag. Both sides idle at random; the
// receiver also holds off for a long stretch to back the block up.
// ----------------------------------------------------------------------------

module tb_top;
  import sqlat_pkg::*;

  localparam int MAX_BURST      = 5;
  localparam int RANDOM_UNTIL   = 440;   // item count at which random text stops
  localparam int CALM_FROM      = 150;   // no idling on either side in this window
  localparam int CALM_TO        = 260;
  localparam int HOLDOFF_AT     = 320;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRINT_CAP      = 40;
  localparam logic [31:0] NULL_WORD = "NULL";

  typedef struct packed {
    event_t     kind;
    logic [7:0] ch;
    logic       last;
  } tok_event_t;

  // one byte of text; typed rows carry their single expected result
  typedef struct packed {
    logic [7:0] text;
    logic       typed;
    event_t     kind;
    logic [7:0] ch;
  } text_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  int   items_in     = 0;
  int   mismatches   = 0;
  int   stall_cycles = 0;
  logic holdoff      = 1'b0;
  logic calm;

  // tokenizer model state
  phase_t     lex_phase  = PH_START;
  logic [2:0] held_len   = 3'd0;
  logic       held_flag  = 1'b0;

  tok_event_t byte_events[$];
  tok_event_t expected_events[$];
  tok_event_t oldest_event;

  // directed text: non-typed rows go through the model
  text_row_t directed_rows [27] = '{
    '{CH_LBRACE, 1'b1, EV_ROW_START, 8'h00},
    '{CH_COMMA,  1'b0, EV_DONE,      8'h00},  // swallowed after a token
    '{CH_SEMI,   1'b1, EV_VALUE_END, 8'h00},  // empty element
    '{"N",       1'b0, EV_DONE,      8'h00},
    '{"U",       1'b0, EV_DONE,      8'h00},
    '{"L",       1'b0, EV_DONE,      8'h00},
    '{"L",       1'b0, EV_DONE,      8'h00},
    '{CH_COMMA,  1'b1, EV_NULL,      8'h00},
    '{"N",       1'b0, EV_DONE,      8'h00},
    '{"U",       1'b0, EV_DONE,      8'h00},
    '{"L",       1'b0, EV_DONE,      8'h00},
    '{"L",       1'b0, EV_DONE,      8'h00},
    '{"Z",       1'b0, EV_DONE,      8'h00},  // releases all four held bytes
    '{CH_RBRACE, 1'b0, EV_DONE,      8'h00},
    '{CH_LBRACE, 1'b1, EV_ROW_START, 8'h00},
    '{CH_SQUOTE, 1'b0, EV_DONE,      8'h00},
    '{8'hFF,     1'b1, EV_BYTE,      8'hFF},
    '{CH_BSLASH, 1'b0, EV_DONE,      8'h00},
    '{CH_COMMA,  1'b1, EV_BYTE,      CH_COMMA},
    '{CH_SQUOTE, 1'b0, EV_DONE,      8'h00},
    '{CH_SQUOTE, 1'b1, EV_BYTE,      CH_SQUOTE},  // doubled quote
    '{CH_SQUOTE, 1'b0, EV_DONE,      8'h00},
    '{CH_DQUOTE, 1'b0, EV_DONE,      8'h00},  // closes quote, opens another
    '{CH_BSLASH, 1'b0, EV_DONE,      8'h00},
    '{CH_DQUOTE, 1'b1, EV_BYTE,      CH_DQUOTE},
    '{8'h01,     1'b1, EV_BYTE,      8'h01},
    '{CH_DQUOTE, 1'b1, EV_VALUE_END, 8'h00}
  };

  sql_array_literal_tokenizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (items_in >= CALM_FROM) && (items_in < CALM_TO);

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] null_letter(input logic [2:0] idx);
    return NULL_WORD[8 * (3 - idx[1:0]) +: 8];
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  task automatic emit(input event_t kind, input logic [7:0] ch);
    tok_event_t ev;
    ev.kind = kind;
    ev.ch   = ch;
    ev.last = 1'b0;
    if (byte_events.size() < MAX_BURST) byte_events = {byte_events, ev};
  endtask

  // hand back the held NULL prefix as ordinary value bytes
  task automatic release_prefix();
    int i;
    for (i = 0; i < held_len && i < 4; i++) emit(EV_BYTE, null_letter(3'(i)));
    held_len = 3'd0;
  endtask

  task automatic unquoted_step(input logic [7:0] c);
    if (is_separator(c) || c == CH_RBRACE || c == CH_NUL) begin
      if (!held_flag && held_len == NULL_LEN) begin
        emit(EV_NULL, 8'h00);
      end else begin
        release_prefix();
        emit(EV_VALUE_END, 8'h00);
      end
      held_len  = 3'd0;
      held_flag = 1'b0;
      if (c == CH_NUL) begin
        emit(EV_DONE, 8'h00);
        lex_phase = PH_END;
      end else if (c == CH_RBRACE) begin
        emit(EV_ROW_END, 8'h00);
        lex_phase = PH_SEP;
      end else begin
        lex_phase = PH_START;
      end
    end else if (!held_flag && held_len < NULL_LEN && c == null_letter(held_len)) begin
      held_len = held_len + 3'd1;
    end else begin
      release_prefix();
      emit(EV_BYTE, c);
      held_flag = 1'b1;
    end
  endtask

  task automatic token_begin(input logic [7:0] c);
    if (c == CH_NUL) begin
      emit(EV_DONE, 8'h00);
      lex_phase = PH_END;
    end else if (c == CH_LBRACE) begin
      emit(EV_ROW_START, 8'h00);
      lex_phase = PH_SEP;
    end else if (c == CH_RBRACE) begin
      emit(EV_ROW_END, 8'h00);
      lex_phase = PH_SEP;
    end else if (c == CH_SQUOTE) begin
      lex_phase = PH_SQ;
    end else if (c == CH_DQUOTE) begin
      lex_phase = PH_DQ;
    end else if (is_separator(c)) begin
      emit(EV_VALUE_END, 8'h00);
      lex_phase = PH_START;
    end else begin
      lex_phase = PH_UNQ;
      held_len  = 3'd0;
      held_flag = 1'b0;
      unquoted_step(c);
    end
  endtask

  task automatic after_token_step(input logic [7:0] c);
    if (is_separator(c)) lex_phase = PH_START;
    else token_begin(c);
  endtask

  // results of one text byte land in byte_events, last one flagged
  task automatic tokenize_byte(input logic [7:0] c);
    byte_events.delete();
    case (lex_phase)
      PH_START: token_begin(c);
      PH_SEP:   after_token_step(c);
      PH_SQ: begin
        if (c == CH_NUL) begin
          emit(EV_ERR_ZERO, 8'h00);
          lex_phase = PH_END;
        end else if (c == CH_SQUOTE) begin
          lex_phase = PH_SQ_QUOTE;
        end else if (c == CH_BSLASH) begin
          held_flag = 1'b0;
          lex_phase = PH_ESC;
        end else begin
          emit(EV_BYTE, c);
        end
      end
      PH_SQ_QUOTE: begin
        if (c == CH_SQUOTE) begin
          emit(EV_BYTE, c);
          lex_phase = PH_SQ;
        end else begin
          emit(EV_VALUE_END, 8'h00);
          lex_phase = PH_SEP;
          after_token_step(c);
        end
      end
      PH_DQ: begin
        if (c == CH_NUL) begin
          emit(EV_ERR_ZERO, 8'h00);
          lex_phase = PH_END;
        end else if (c == CH_BSLASH) begin
          held_flag = 1'b1;
          lex_phase = PH_ESC;
        end else if (c == CH_DQUOTE) begin
          emit(EV_VALUE_END, 8'h00);
          lex_phase = PH_SEP;
        end else begin
          emit(EV_BYTE, c);
        end
      end
      PH_ESC: begin
        if (c == CH_NUL) begin
          emit(EV_ERR_ESC, 8'h00);
          lex_phase = PH_END;
        end else begin
          emit(EV_BYTE, c);
          lex_phase = held_flag ? PH_DQ : PH_SQ;
        end
        held_flag = 1'b0;
      end
      PH_UNQ: unquoted_step(c);
      default: begin
        emit(EV_DONE, 8'h00);
        lex_phase = PH_END;
      end
    endcase
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_item(input text_row_t r);
    tok_event_t ev;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.text;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokenize_byte(r.text);
    if (r.typed) begin
      ev.kind = r.kind;
      ev.ch   = r.ch;
      ev.last = 1'b1;
      expected_events = {expected_events, ev};
    end else begin
      expected_events = {expected_events, byte_events};
    end
    items_in++;
  endtask

  task automatic put_text(input logic [7:0] b);
    text_row_t r;
    r.text  = b;
    r.typed = 1'b0;
    r.kind  = EV_DONE;
    r.ch    = 8'h00;
    send_item(r);
  endtask

  // quote == CH_NUL: character for an unquoted element, else for that string
  function automatic logic [7:0] rand_char(input logic [7:0] quote);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while ((quote == CH_NUL) ?
               (is_separator(c) || c == CH_RBRACE || c == CH_LBRACE ||
                c == CH_SQUOTE || c == CH_DQUOTE) :
               (c == quote || c == CH_BSLASH));
    return c;
  endfunction

  task automatic quoted_element(input logic [7:0] quote);
    int n;
    int i;
    int pick;
    n = $urandom_range(0, 6);
    put_text(quote);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick == 0 && quote == CH_SQUOTE) begin
        put_text(CH_SQUOTE);
        put_text(CH_SQUOTE);
      end else if (pick == 1) begin
        put_text(CH_BSLASH);
        put_text(8'($urandom_range(1, 255)));
      end else begin
        put_text(rand_char(quote));
      end
    end
    put_text(quote);
  endtask

  // one random piece of array literal, possibly followed by a separator
  task automatic random_element();
    int sel;
    int n;
    int i;
    int flip;
    sel = $urandom_range(99);
    if (sel < 12) begin
      put_text(CH_LBRACE);
    end else if (sel < 22) begin
      put_text(CH_RBRACE);
    end else if (sel < 30) begin
      put_text($urandom_range(1) ? CH_COMMA : CH_SEMI);
    end else if (sel < 55) begin
      case ($urandom_range(5))
        0: for (i = 0; i < 4; i++) put_text(null_letter(3'(i)));
        1: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) put_text(null_letter(3'(i)));
          n = $urandom_range(0, 3);
          for (i = 0; i < n; i++) put_text(rand_char(CH_NUL));
        end
        2: begin
          // NULL with one letter in the wrong case
          flip = $urandom_range(3);
          for (i = 0; i < 4; i++)
            put_text(null_letter(3'(i)) ^ ((i == flip) ? 8'h20 : 8'h00));
        end
        default: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) put_text(rand_char(CH_NUL));
        end
      endcase
    end else if (sel < 72) begin
      quoted_element(CH_SQUOTE);
    end else if (sel < 88) begin
      quoted_element(CH_DQUOTE);
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) put_text(8'($urandom_range(1, 255)));
    end
    if ($urandom_range(99) < 60) put_text($urandom_range(1) ? CH_COMMA : CH_SEMI);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, long hold-off and result checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= !holdoff && (calm || $urandom_range(99) >= 15);
  end

  initial begin
    wait (items_in >= HOLDOFF_AT);
    @(posedge clk);
    holdoff = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holdoff = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %02h last %0b",
                                  out_tuser, out_tdata, out_tlast));
      end else begin
        oldest_event = expected_events.pop_front();
        if (out_tuser !== oldest_event.kind)
          report_mismatch($sformatf("kind %0d, expected %s",
                                    out_tuser, oldest_event.kind.name()));
        if (out_tdata !== oldest_event.ch)
          report_mismatch($sformatf("char %02h, expected %02h",
                                    out_tdata, oldest_event.ch));
        if (out_tlast !== oldest_event.last)
          report_mismatch($sformatf("last %0b, expected %0b",
                                    out_tlast, oldest_event.last));
      end
    end
  end

  // watchdog: cycles in which no item moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    while (items_in < RANDOM_UNTIL) random_element();

    // close whatever element is open so the ending starts at a token boundary
    while (lex_phase != PH_START && lex_phase != PH_SEP) begin
      case (lex_phase)
        PH_SQ:   put_text(CH_SQUOTE);
        PH_DQ:   put_text(CH_DQUOTE);
        PH_ESC:  put_text("a");
        default: put_text(CH_COMMA);
      endcase
    end

    // one way of ending the text per run
    case ($urandom_range(4))
      0: put_text(CH_NUL);
      1: begin
        put_text(CH_SQUOTE);
        put_text("a");
        put_text(CH_NUL);
      end
      2: begin
        put_text(CH_DQUOTE);
        put_text(CH_BSLASH);
        put_text(CH_NUL);
      end
      3: begin
        put_text("a");
        put_text("b");
        put_text(CH_NUL);
      end
      default: begin
        put_text("N");
        put_text("U");
        put_text("L");
        put_text("L");
        put_text(CH_NUL);
      end
    endcase

    // ended: each further byte just reports done
    repeat (6) put_text(8'($urandom_range(255)));

    @(negedge clk) in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sqlat_pkg.sv
rtl/core/sqlat_decode.sv
rtl/core/sql_array_literal_tokenizer.sv
tb/tb_top.sv
